[rtl/core/clst_pkg.sv]
// ----------------------------------------------------------------------------
// clst_pkg: shared types and constants of the compacting list store
// Field widths, operation codes, beat layouts and the control word that
// steers each storage cell.
// ----------------------------------------------------------------------------
package clst_pkg;

    // Field widths fixed by the beat formats
    localparam int unsigned VALUE_W     = 32;
    localparam int unsigned POS_W       = 5;
    localparam int unsigned OPCODE_W    = 2;
    localparam int unsigned COUNT_OUT_W = 6;

    // Input beat layout: opcode, value_in, position, one pad bit
    localparam int unsigned IN_OP_LSB   = 0;
    localparam int unsigned IN_VAL_LSB  = IN_OP_LSB + OPCODE_W;
    localparam int unsigned IN_POS_LSB  = IN_VAL_LSB + VALUE_W;
    localparam int unsigned IN_BITS     = IN_POS_LSB + POS_W;
    localparam int unsigned IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;

    // Output beat layout: accepted, count_after, value_out, one pad bit
    localparam int unsigned OUT_ACC_LSB  = 0;
    localparam int unsigned OUT_CNT_LSB  = OUT_ACC_LSB + 1;
    localparam int unsigned OUT_VAL_LSB  = OUT_CNT_LSB + COUNT_OUT_W;
    localparam int unsigned OUT_BITS     = OUT_VAL_LSB + VALUE_W;
    localparam int unsigned OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

    // Operation codes
    typedef enum logic [OPCODE_W-1:0] {
        OP_APPEND = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2
    } opcode_t;

    typedef logic [VALUE_W-1:0] value_t;

    // Per-cell steering: load the appended value or take the upper neighbour
    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

endpackage

[rtl/core/clst_cell.sv]
// ----------------------------------------------------------------------------
// clst_cell: one storage cell of the list chain
// Holds one entry. It loads the appended value, takes its upper neighbour's
// entry when a removal closes the gap, or keeps what it holds.
// ----------------------------------------------------------------------------
module clst_cell (
    input  logic                clk,
    input  clst_pkg::cell_ctrl_t ctrl,
    input  clst_pkg::value_t    append_value,
    input  clst_pkg::value_t    upper_value,
    output clst_pkg::value_t    value
);

    clst_pkg::value_t data_reg;
    clst_pkg::value_t data_next;

    // Select the next content of the cell
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.load)
        begin
            data_next = append_value;
        end
        else if (ctrl.shift)
        begin
            data_next = upper_value;
        end
    end

    // Entry storage; contents are undefined until written
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign value = data_reg;

endmodule

[rtl/core/compacting_list_store_core.sv]
// ----------------------------------------------------------------------------
// compacting_list_store_core: bounded ordered list with compacting removal
// Appends at the tail, removes at a position with every later entry moving
// down one cell, and reads at a position. Each beat gives one result beat.
// ----------------------------------------------------------------------------
//  channel | dir | payload (low bit first)                    | handshake
//  s_*     | in  | opcode[2], value_in[32], position[5], pad  | tvalid/tready
//  m_*     | out | accepted, count_after[6], value_out[32], pad | tvalid/tready
//
// The whole chain of cells shifts in the cycle the beat is accepted and the
// result is registered on the output.
// One beat per cycle is sustained while the output is taken.
// A new beat is accepted while the output register is empty or being taken.
// Reset empties the list and the output; entry cells are not cleared.
// ----------------------------------------------------------------------------
module compacting_list_store_core #(
    parameter int unsigned MAX_ENTRIES = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // opcode [1:0], value_in [33:2], position [38:34], zero [39]
    input  logic [clst_pkg::IN_TDATA_W-1:0]        s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // accepted [0], count_after [6:1], value_out [38:7], zero [39]
    output logic [clst_pkg::OUT_TDATA_W-1:0]       m_tdata
);

    localparam int unsigned CNT_W    = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned EXT_W    = (CNT_W > clst_pkg::COUNT_OUT_W) ?
                                       CNT_W : clst_pkg::COUNT_OUT_W;
    localparam int unsigned RD_CELLS = (MAX_ENTRIES < (1 << clst_pkg::POS_W)) ?
                                       MAX_ENTRIES : (1 << clst_pkg::POS_W);
    localparam int unsigned RD_IDX_W = $clog2(RD_CELLS);

    // Unpacked input fields
    logic [clst_pkg::OPCODE_W-1:0] in_opcode;
    clst_pkg::value_t              in_value;
    logic [clst_pkg::POS_W-1:0]    in_pos;

    logic                          in_fire;
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic [EXT_W-1:0]              count_ext;
    logic [EXT_W-1:0]              pos_ext;
    logic [EXT_W-1:0]              count_next_ext;
    logic                          pos_ok;
    logic                          append_ok;
    logic                          remove_ok;
    logic                          read_ok;
    logic                          accept_op;
    clst_pkg::value_t              read_value;
    clst_pkg::value_t              result_value;

    clst_pkg::cell_ctrl_t          cell_ctrl  [MAX_ENTRIES];
    clst_pkg::value_t              cell_value [MAX_ENTRIES];
    clst_pkg::value_t              cell_upper [MAX_ENTRIES];

    logic                          out_valid_reg;
    logic                          out_acc_reg;
    logic [clst_pkg::COUNT_OUT_W-1:0] out_cnt_reg;
    clst_pkg::value_t              out_val_reg;

    assign in_opcode = s_tdata[clst_pkg::IN_OP_LSB +: clst_pkg::OPCODE_W];
    assign in_value  = s_tdata[clst_pkg::IN_VAL_LSB +: clst_pkg::VALUE_W];
    assign in_pos    = s_tdata[clst_pkg::IN_POS_LSB +: clst_pkg::POS_W];

    // Output register frees when empty or being drained
    assign s_tready = !out_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    // Decode the operation and its acceptance
    assign count_ext = EXT_W'(count_reg);
    assign pos_ext   = EXT_W'(in_pos);
    assign pos_ok    = pos_ext < count_ext;

    always_comb
    begin
        append_ok = 1'b0;
        remove_ok = 1'b0;
        read_ok   = 1'b0;
        case (in_opcode)
            clst_pkg::OP_APPEND: append_ok = count_reg != CNT_W'(MAX_ENTRIES);
            clst_pkg::OP_REMOVE: remove_ok = pos_ok;
            clst_pkg::OP_READ:   read_ok   = pos_ok;
            default:             ;
        endcase
    end

    assign accept_op = append_ok || remove_ok || read_ok;

    // Entry count update
    always_comb
    begin
        count_next = count_reg;
        if (in_fire && append_ok)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (in_fire && remove_ok)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Chain of cells: on removal each cell at or above the position takes its upper neighbour
    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        assign cell_ctrl[i].load  = in_fire && append_ok &&
                                    (count_reg == CNT_W'(i));
        assign cell_ctrl[i].shift = in_fire && remove_ok &&
                                    (EXT_W'(i) >= pos_ext);

        if (i + 1 < MAX_ENTRIES)
        begin : g_mid
            assign cell_upper[i] = cell_value[i + 1];
        end
        else
        begin : g_top
            assign cell_upper[i] = '0;
        end

        clst_cell u_cell (
            .clk          (clk),
            .ctrl         (cell_ctrl[i]),
            .append_value (in_value),
            .upper_value  (cell_upper[i]),
            .value        (cell_value[i])
        );
    end

    // Read port over the cells that a position can address
    always_comb
    begin
        read_value = cell_value[in_pos[RD_IDX_W-1:0]];
    end

    assign result_value   = read_ok ? read_value : '0;
    assign count_next_ext = EXT_W'(count_next);

    // Output register: valid is control, fields are payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            out_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_acc_reg <= accept_op;
            out_cnt_reg <= count_next_ext[clst_pkg::COUNT_OUT_W-1:0];
            out_val_reg <= result_value;
        end
    end

    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        m_tdata = '0;
        m_tdata[clst_pkg::OUT_ACC_LSB] = out_acc_reg;
        m_tdata[clst_pkg::OUT_CNT_LSB +: clst_pkg::COUNT_OUT_W] = out_cnt_reg;
        m_tdata[clst_pkg::OUT_VAL_LSB +: clst_pkg::VALUE_W] = out_val_reg;
    end

`ifndef SYNTHESIS
    // The list never holds more than its capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ENTRIES))
    else $error("entry count beyond capacity");

    // An accepted append grows the list by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && append_ok) |=> count_reg == $past(count_reg) + CNT_W'(1))
    else $error("append did not grow the list");

    // An accepted remove shrinks the list by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && remove_ok) |=> count_reg == $past(count_reg) - CNT_W'(1))
    else $error("remove did not shrink the list");

    // A stalled result blocks the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while result stalled");

    // Rejected results carry a zero value
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !out_acc_reg) |-> (out_val_reg == '0))
    else $error("rejected result with non-zero value");
`endif

endmodule

[dv/compacting_list_store_checker.sv]
// ----------------------------------------------------------------------------
// compacting_list_store_checker: scoreboard for the compacting list store
// Watches the input and output stream channels, keeps its own copy of the
// list, works out the result of every accepted input beat and compares each
// output beat, field by field, with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module compacting_list_store_checker #(
    parameter int unsigned CAPACITY = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    // opcode, value_in, position, zero pad
    input  logic [clst_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    // accepted, count_after, value_out, zero pad
    input  logic [clst_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output int                                  fail_count,
    output int                                  pending,
    output int                                  appends_done,
    output int                                  removes_done,
    output int                                  reads_done,
    output int                                  refusals,
    output int                                  peak_fill
);

    typedef struct packed {
        logic                              accepted;
        logic [clst_pkg::COUNT_OUT_W-1:0]  count_after;
        clst_pkg::value_t                  value_out;
    } list_result_t;

    // Shadow copy of the list and the results still owed by the block
    clst_pkg::value_t shadow_list [CAPACITY];
    int unsigned      shadow_len;
    list_result_t     owed_results [$];

    // Applies one operation to the shadow list and returns its result
    function automatic list_result_t apply_list_op(
        input logic [clst_pkg::OPCODE_W-1:0] op,
        input clst_pkg::value_t              value,
        input logic [clst_pkg::POS_W-1:0]    pos
    );
        list_result_t res;
        int unsigned  idx;
        res = '0;
        case (op)
            clst_pkg::OP_APPEND:
            begin
                if (shadow_len < CAPACITY)
                begin
                    shadow_list[shadow_len] = value;
                    shadow_len++;
                    res.accepted = 1'b1;
                end
            end
            clst_pkg::OP_REMOVE:
            begin
                if (pos < shadow_len)
                begin
                    // Close the gap: every later entry moves down one place
                    for (idx = pos; idx + 1 < shadow_len; idx++)
                        shadow_list[idx] = shadow_list[idx + 1];
                    shadow_len--;
                    res.accepted = 1'b1;
                end
            end
            clst_pkg::OP_READ:
            begin
                if (pos < shadow_len)
                begin
                    res.value_out = shadow_list[pos];
                    res.accepted  = 1'b1;
                end
            end
            default:
            begin
                // The spare opcode is refused and changes nothing
            end
        endcase
        res.count_after = clst_pkg::COUNT_OUT_W'(shadow_len);
        return res;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h",
                     $time, field, want_v, got_v);
        end
    endtask

    // Output beats are compared before the input beat of the same edge is
    // queued, since a result can never leave in the cycle its operation enters.
    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        list_result_t                      want;
        logic [clst_pkg::OPCODE_W-1:0]     beat_op;
        logic                              got_accepted;
        logic [clst_pkg::COUNT_OUT_W-1:0]  got_count;
        clst_pkg::value_t                  got_value;
        if (!rst_n)
        begin
            shadow_len = 0;
            owed_results.delete();
            pending = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got_accepted = m_tdata[clst_pkg::OUT_ACC_LSB];
                got_count    = m_tdata[clst_pkg::OUT_CNT_LSB +: clst_pkg::COUNT_OUT_W];
                got_value    = m_tdata[clst_pkg::OUT_VAL_LSB +: clst_pkg::VALUE_W];
                if (owed_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result beat, expected none, actual 0x%010h",
                             $time, m_tdata);
                end
                else
                begin
                    want = owed_results.pop_front();
                    check_field("accepted", 32'(want.accepted), 32'(got_accepted));
                    check_field("count_after", 32'(want.count_after), 32'(got_count));
                    check_field("value_out", want.value_out, got_value);
                end
            end

            if (s_tvalid && s_tready)
            begin
                beat_op = s_tdata[clst_pkg::IN_OP_LSB +: clst_pkg::OPCODE_W];
                want = apply_list_op(beat_op,
                                     s_tdata[clst_pkg::IN_VAL_LSB +: clst_pkg::VALUE_W],
                                     s_tdata[clst_pkg::IN_POS_LSB +: clst_pkg::POS_W]);
                owed_results.push_back(want);

                // Tally what the run has exercised
                if (!want.accepted)
                    refusals++;
                else if (beat_op == clst_pkg::OP_APPEND)
                    appends_done++;
                else if (beat_op == clst_pkg::OP_REMOVE)
                    removes_done++;
                else
                    reads_done++;
                if (int'(shadow_len) > peak_fill)
                    peak_fill = int'(shadow_len);
            end

            pending = owed_results.size();
        end
    end

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench top for the compacting list store
// Drives a directed sequence over the empty, edge and out-of-range cases,
// then random operation mixes that fill the list to capacity and drain it,
// with random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned                  LIST_DEPTH      = 32;
    localparam logic [clst_pkg::OPCODE_W-1:0] OP_SPARE       = 2'd3;
    localparam int                           RANDOM_ITEMS    = 400;
    localparam int                           CALM_ITEMS      = 100;
    localparam int                           ROUND_LEN       = 48;
    localparam int                           HOLD_OFF_AT     = 70;
    localparam int                           HOLD_OFF_CYCLES = 80;
    localparam int                           QUIET_LIMIT     = 2000;
    localparam int                           SETTLE_CYCLES   = 4;

    typedef enum int {
        MIX_FILL,
        MIX_BALANCED,
        MIX_DRAIN
    } op_mix_t;

    logic                             clk;
    logic                             rst_n;
    logic                             s_tvalid;
    logic                             s_tready;
    // opcode, value_in, position, zero pad
    logic [clst_pkg::IN_TDATA_W-1:0]  s_tdata;
    logic                             m_tvalid;
    logic                             m_tready;
    // accepted, count_after, value_out, zero pad
    logic [clst_pkg::OUT_TDATA_W-1:0] m_tdata;

    int fail_count;
    int pending;
    int appends_done;
    int removes_done;
    int reads_done;
    int refusals;
    int peak_fill;

    bit          idling_on;
    bit          hold_off_req;
    int unsigned fill_guess;

    compacting_list_store_core #(
        .MAX_ENTRIES (LIST_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    compacting_list_store_checker #(
        .CAPACITY (LIST_DEPTH)
    ) list_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .fail_count   (fail_count),
        .pending      (pending),
        .appends_done (appends_done),
        .removes_done (removes_done),
        .reads_done   (reads_done),
        .refusals     (refusals),
        .peak_fill    (peak_fill)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Offers one operation beat, waits for it to be taken, then perhaps idles
    task automatic issue_op(input logic [clst_pkg::OPCODE_W-1:0] op,
                            input clst_pkg::value_t value,
                            input logic [clst_pkg::POS_W-1:0] pos);
        logic [clst_pkg::IN_TDATA_W-1:0] beat;
        beat = '0;
        beat[clst_pkg::IN_OP_LSB +: clst_pkg::OPCODE_W] = op;
        beat[clst_pkg::IN_VAL_LSB +: clst_pkg::VALUE_W] = value;
        beat[clst_pkg::IN_POS_LSB +: clst_pkg::POS_W]   = pos;
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);

        // Rough fill level, used only to steer positions into range
        if (op == clst_pkg::OP_APPEND && fill_guess < LIST_DEPTH)
            fill_guess++;
        else if (op == clst_pkg::OP_REMOVE && pos < fill_guess)
            fill_guess--;

        if (idling_on && !hold_off_req && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    function automatic logic [clst_pkg::POS_W-1:0] pick_position();
        if (fill_guess > 0 && $urandom_range(0, 9) < 8)
            return clst_pkg::POS_W'($urandom_range(0, fill_guess - 1));
        return clst_pkg::POS_W'($urandom_range(0, 31));
    endfunction

    function automatic clst_pkg::value_t pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [clst_pkg::OPCODE_W-1:0] pick_opcode(input op_mix_t mix);
        int roll;
        int append_w;
        int remove_w;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:
            begin
                append_w = 85;
                remove_w = 4;
            end
            MIX_DRAIN:
            begin
                append_w = 5;
                remove_w = 75;
            end
            default:
            begin
                append_w = 40;
                remove_w = 30;
            end
        endcase
        if (roll < append_w)
            return clst_pkg::OP_APPEND;
        if (roll < append_w + remove_w)
            return clst_pkg::OP_REMOVE;
        if (roll < 97)
            return clst_pkg::OP_READ;
        return OP_SPARE;
    endfunction

    // Output side: random stalls, one long hold-off on request, none at the end
    initial
    begin
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else if (idling_on && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // Ends the run if neither channel moves a beat for too long
    initial
    begin : quiet_watch
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
                 $time, QUIET_LIMIT, pending);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : stimulus
        op_mix_t mix;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        rst_n        = 1'b0;
        idling_on    = 1'b1;
        hold_off_req = 1'b0;
        fill_guess   = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty list: read and remove are refused, as is the spare opcode
        issue_op(clst_pkg::OP_READ, '0, 5'd0);
        issue_op(clst_pkg::OP_REMOVE, '0, 5'd0);
        issue_op(OP_SPARE, '0, 5'd0);
        // Extreme values in, then read them back
        issue_op(clst_pkg::OP_APPEND, 32'h7FFF_FFFF, 5'd31);
        issue_op(clst_pkg::OP_APPEND, 32'h8000_0000, 5'd0);
        issue_op(clst_pkg::OP_APPEND, '0, 5'd0);
        issue_op(clst_pkg::OP_APPEND, '1, 5'd0);
        issue_op(clst_pkg::OP_APPEND, 32'h0000_0001, 5'd0);
        issue_op(clst_pkg::OP_READ, '0, 5'd0);
        issue_op(clst_pkg::OP_READ, '1, 5'd1);
        issue_op(clst_pkg::OP_READ, '0, 5'd4);
        // Positions at and beyond the count are refused
        issue_op(clst_pkg::OP_READ, '0, 5'd5);
        issue_op(clst_pkg::OP_READ, '0, 5'd31);
        issue_op(clst_pkg::OP_REMOVE, '0, 5'd31);
        issue_op(OP_SPARE, '1, 5'd31);
        // Remove the last, the first and a middle entry, then empty the list
        issue_op(clst_pkg::OP_REMOVE, '0, 5'd4);
        issue_op(clst_pkg::OP_REMOVE, '0, 5'd0);
        issue_op(clst_pkg::OP_READ, '0, 5'd0);
        issue_op(clst_pkg::OP_REMOVE, '0, 5'd1);
        issue_op(clst_pkg::OP_READ, '0, 5'd1);
        issue_op(clst_pkg::OP_REMOVE, '0, 5'd0);
        issue_op(clst_pkg::OP_REMOVE, '0, 5'd0);
        issue_op(clst_pkg::OP_READ, '0, 5'd0);

        // Random rounds that alternate between filling, mixing and draining
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            mix = op_mix_t'((i / ROUND_LEN) % 3);
            if (i == HOLD_OFF_AT)
                hold_off_req = 1'b1;
            if (i == RANDOM_ITEMS - CALM_ITEMS)
                idling_on = 1'b0;
            issue_op(pick_opcode(mix), pick_value(), pick_position());
        end
        s_tvalid <= 1'b0;

        // Let the checker queue the last beat before waiting for the drain
        @(posedge clk);
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d appends, %0d removes and %0d reads accepted, %0d refused,",
                 appends_done, removes_done, reads_done, refusals);
        $display("with the list filled up to %0d of %0d entries.", peak_fill, LIST_DEPTH);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
